### design/bse_pkg.sv
package bse_pkg;

  localparam int FRAC_BITS     = 28;
  localparam int COORD_BITS    = 14;
  localparam int ITER_BITS     = 10;
  localparam int VAL_BITS      = FRAC_BITS + 4;
  localparam int STEP_BITS     = 31;
  localparam int GRAY_BITS     = 8;
  localparam int BIT_IDX_BITS  = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // 255^2 and (2*255)^2 for the square root search and the final rounding
  localparam int GRAY_SCALE  = 65025;
  localparam int GRAY_SCALE4 = 260100;

  localparam logic [CFG_IDX_BITS-1:0] REG_X_ORIGIN   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_ORIGIN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_STEP     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_STEP     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ITER_LIMIT = 3'd4;

  localparam logic signed [VAL_BITS-1:0] RST_X_ORIGIN   = -32'sd590558003;
  localparam logic signed [VAL_BITS-1:0] RST_Y_ORIGIN   = -32'sd590558003;
  localparam logic [STEP_BITS-1:0]       RST_X_STEP     = 31'd109363;
  localparam logic [STEP_BITS-1:0]       RST_Y_STEP     = 31'd123033;
  localparam logic [ITER_BITS-1:0]       RST_ITER_LIMIT = 10'd500;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_ADD,
    S_ITER_MUL,
    S_ITER_UPD,
    S_GRAY_INIT,
    S_GRAY_SQ,
    S_GRAY_CMP,
    S_FIN_SQ,
    S_FIN_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                    load;
    logic                    map_mul;
    logic                    map_add;
    logic                    iter_mul;
    logic                    iter_upd;
    logic                    gray_init;
    logic                    gray_sq;
    logic                    gray_cmp;
    logic                    fin_sq;
    logic                    fin_cmp;
    logic                    out_load;
    logic [BIT_IDX_BITS-1:0] bit_idx;
  } cmd_t;

  typedef struct packed {
    logic iter_done;
  } stat_t;

endpackage

### design/burning_ship_escape_time.sv
// Each iteration runs a shared multiply stage, then the bound test and update;
// before the iterations come the coordinate mapping steps, and after them a
// bit-serial square root for gray and its final rounding.
// One pixel is processed at a time: a new pixel is accepted only once the last
// one has finished; the next pixel is taken while a finished result waits in
// the output register.
// Reset: registers return to their default view, engine idle, no result held.
module burning_ship_escape_time (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bse_pkg::COORD_BITS-1:0]       row,
  input  logic [bse_pkg::COORD_BITS-1:0]       col,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bse_pkg::COORD_BITS-1:0]       out_row,
  output logic [bse_pkg::COORD_BITS-1:0]       out_col,
  output logic [bse_pkg::ITER_BITS-1:0]        iter_count,
  output logic [bse_pkg::GRAY_BITS-1:0]        gray,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bse_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bse_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import bse_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bse_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .row        (row),
    .col        (col),
    .cmd        (cmd),
    .stat       (stat),
    .out_row    (out_row),
    .out_col    (out_col),
    .iter_count (iter_count),
    .gray       (gray)
  );

endmodule

### design/bse_ctrl.sv
module bse_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bse_pkg::stat_t stat,
  output bse_pkg::cmd_t  cmd
);
  import bse_pkg::*;

  state_t                  state, state_next;
  logic [BIT_IDX_BITS-1:0] bit_idx, bit_idx_next;
  logic                    out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bit_idx   <= bit_idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_MAP_MUL;
      S_MAP_MUL:   state_next = S_MAP_ADD;
      S_MAP_ADD:   state_next = S_ITER_MUL;
      S_ITER_MUL:  state_next = S_ITER_UPD;
      S_ITER_UPD:  state_next = stat.iter_done ? S_GRAY_INIT : S_ITER_MUL;
      S_GRAY_INIT: state_next = S_GRAY_SQ;
      S_GRAY_SQ:   state_next = S_GRAY_CMP;
      S_GRAY_CMP:  state_next = (bit_idx == '0) ? S_FIN_SQ : S_GRAY_SQ;
      S_FIN_SQ:    state_next = S_FIN_CMP;
      S_FIN_CMP:   state_next = S_DONE;
      S_DONE:      if (!out_valid || out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.bit_idx  = bit_idx;
    in_ready     = 1'b0;
    bit_idx_next = bit_idx;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MAP_MUL:   cmd.map_mul  = 1'b1;
      S_MAP_ADD:   cmd.map_add  = 1'b1;
      S_ITER_MUL:  cmd.iter_mul = 1'b1;
      S_ITER_UPD:  cmd.iter_upd = 1'b1;
      S_GRAY_INIT: begin
        cmd.gray_init = 1'b1;
        bit_idx_next  = BIT_IDX_BITS'(GRAY_BITS - 1);
      end
      S_GRAY_SQ:   cmd.gray_sq = 1'b1;
      S_GRAY_CMP: begin
        cmd.gray_cmp = 1'b1;
        bit_idx_next = bit_idx - 1'b1;
      end
      S_FIN_SQ:    cmd.fin_sq  = 1'b1;
      S_FIN_CMP:   cmd.fin_cmp = 1'b1;
      S_DONE:      cmd.out_load = !out_valid || out_ready;
      default:     cmd = '0;
    endcase
  end

  // output register frees on transfer, refills from the finished pixel
  always_comb begin
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before transfer");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MAP_MUL))
    else $error("accepted pixel did not start mapping");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_iter_exit: assert property (@(posedge clk) disable iff (rst)
    (cmd.iter_upd && stat.iter_done) |=> (state == S_GRAY_INIT))
    else $error("iteration end not followed by gray computation");

  a_search_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.gray_cmp && bit_idx == '0) |=> (state == S_FIN_SQ))
    else $error("square root search ran past last bit");

endmodule

### design/bse_dp.sv
module bse_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bse_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bse_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic [bse_pkg::COORD_BITS-1:0]       row,
  input  logic [bse_pkg::COORD_BITS-1:0]       col,
  input  bse_pkg::cmd_t                        cmd,
  output bse_pkg::stat_t                       stat,
  output logic [bse_pkg::COORD_BITS-1:0]       out_row,
  output logic [bse_pkg::COORD_BITS-1:0]       out_col,
  output logic [bse_pkg::ITER_BITS-1:0]        iter_count,
  output logic [bse_pkg::GRAY_BITS-1:0]        gray
);
  import bse_pkg::*;

  localparam int SUM_W  = 48;
  localparam int PROD_W = COORD_BITS + STEP_BITS;
  localparam int GX_W   = 2 * GRAY_BITS + ITER_BITS;
  localparam int X4_W   = 2 * GRAY_BITS + 2 + ITER_BITS;
  localparam int SQ2_W  = 2 * GRAY_BITS + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-VAL_BITS+1){1'b0}}, {(VAL_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [VAL_BITS-1:0] FOUR = VAL_BITS'(1) << (FRAC_BITS + 2);

  function automatic logic signed [VAL_BITS-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_BITS-1:0] r;
    if (v > SAT_HI) r = SAT_HI[VAL_BITS-1:0];
    else if (v < SAT_LO) r = SAT_LO[VAL_BITS-1:0];
    else r = v[VAL_BITS-1:0];
    return r;
  endfunction

  // (a*b) >> FRAC_BITS, clipped to the largest positive value
  function automatic logic [VAL_BITS-2:0] mul_sat(input logic [VAL_BITS-1:0] a,
                                                  input logic [VAL_BITS-1:0] b);
    logic [2*VAL_BITS-1:0] p;
    logic [VAL_BITS-2:0]   r;
    p = a * b;
    if (|p[2*VAL_BITS-1:FRAC_BITS+VAL_BITS-1]) r = '1;
    else r = p[FRAC_BITS+VAL_BITS-2:FRAC_BITS];
    return r;
  endfunction

  logic signed [VAL_BITS-1:0] x_origin, y_origin;
  logic [STEP_BITS-1:0]       x_step, y_step;
  logic [ITER_BITS-1:0]       iter_limit;

  logic [COORD_BITS-1:0]      row_q, col_q;
  logic [PROD_W-1:0]          prod_x, prod_y;
  logic signed [VAL_BITS-1:0] cr, ci, zr, zi;
  logic [VAL_BITS-2:0]        zr2, zi2, zp;
  logic [ITER_BITS-1:0]       count;
  logic [GX_W-1:0]            gx;
  logic [GRAY_BITS-1:0]       n;
  logic [2*GRAY_BITS-1:0]     sq;
  logic [SQ2_W-1:0]           sq2;
  logic [X4_W-1:0]            x4;
  logic [GRAY_BITS-1:0]       gray_q;

  logic [VAL_BITS-1:0]        ar, ai;
  logic [VAL_BITS-1:0]        bound;
  logic signed [SUM_W-1:0]    re_sum, im_sum, cx_sum, cy_sum;
  logic [GRAY_BITS-1:0]       trial;
  logic [GRAY_BITS:0]         odd;
  logic [X4_W-1:0]            y4;
  logic [GRAY_BITS-1:0]       gray_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin   <= RST_X_ORIGIN;
      y_origin   <= RST_Y_ORIGIN;
      x_step     <= RST_X_STEP;
      y_step     <= RST_Y_STEP;
      iter_limit <= RST_ITER_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_ORIGIN:   x_origin   <= cfg_data[VAL_BITS-1:0];
        REG_Y_ORIGIN:   y_origin   <= cfg_data[VAL_BITS-1:0];
        REG_X_STEP:     x_step     <= cfg_data[STEP_BITS-1:0];
        REG_Y_STEP:     y_step     <= cfg_data[STEP_BITS-1:0];
        REG_ITER_LIMIT: iter_limit <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ar     = zr[VAL_BITS-1] ? (~zr + 1'b1) : zr;
    ai     = zi[VAL_BITS-1] ? (~zi + 1'b1) : zi;
    cx_sum = $signed({{(SUM_W-PROD_W){1'b0}}, prod_x}) + SUM_W'(x_origin);
    cy_sum = $signed({{(SUM_W-PROD_W){1'b0}}, prod_y}) + SUM_W'(y_origin);
    bound  = {1'b0, zr2} + {1'b0, zi2};
    re_sum = $signed({{(SUM_W-VAL_BITS+1){1'b0}}, zr2})
           - $signed({{(SUM_W-VAL_BITS+1){1'b0}}, zi2}) + SUM_W'(cr);
    im_sum = $signed({{(SUM_W-VAL_BITS){1'b0}}, zp, 1'b0}) + SUM_W'(ci);
    stat.iter_done = (count == iter_limit) || (bound >= FOUR);
    trial  = n | (GRAY_BITS'(1) << cmd.bit_idx);
    odd    = {n, 1'b1};
    y4     = X4_W'(sq2) * X4_W'(iter_limit);
    // round half to even between n and n+1
    if (iter_limit == '0) gray_calc = '0;
    else if (n == '1) gray_calc = n;
    else if (x4 > y4) gray_calc = n + 1'b1;
    else if (x4 == y4) gray_calc = n[0] ? n + 1'b1 : n;
    else gray_calc = n;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_q <= row;
      col_q <= col;
    end
    if (cmd.map_mul) begin
      prod_x <= col_q * x_step;
      prod_y <= row_q * y_step;
    end
    if (cmd.map_add) begin
      cr    <= sat_val(cx_sum);
      ci    <= sat_val(cy_sum);
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end
    if (cmd.iter_mul) begin
      zr2 <= mul_sat(ar, ar);
      zi2 <= mul_sat(ai, ai);
      zp  <= mul_sat(ar, ai);
    end
    if (cmd.iter_upd && !stat.iter_done) begin
      count <= count + 1'b1;
      zr    <= sat_val(re_sum);
      zi    <= sat_val(im_sum);
    end
    if (cmd.gray_init) begin
      gx <= GX_W'(GRAY_SCALE * count);
      n  <= '0;
    end
    if (cmd.gray_sq) sq <= trial * trial;
    if (cmd.gray_cmp && (GX_W'(sq) * GX_W'(iter_limit) <= gx)) n <= trial;
    if (cmd.fin_sq) begin
      sq2 <= odd * odd;
      x4  <= X4_W'(GRAY_SCALE4 * count);
    end
    if (cmd.fin_cmp) gray_q <= gray_calc;
    if (cmd.out_load) begin
      out_row    <= row_q;
      out_col    <= col_q;
      iter_count <= count;
      gray       <= gray_q;
    end
  end

endmodule
